[sv/tmc_pkg.sv]
// ----------------------------------------------------------------------------
// Thermometer menu controller package
// Shared types, key masks, view modes and reset constants.
// ----------------------------------------------------------------------------
package tmc_pkg;

  // Key masks of the active-low key sample, after inversion.
  localparam logic [4:0] KEYS_ALL  = 5'h1F;
  localparam logic [4:0] KEY_VIEW  = 5'h01;
  localparam logic [4:0] KEY_RESET = 5'h02;
  localparam logic [4:0] KEY_SET   = 5'h04;
  localparam logic [4:0] KEY_DOWN  = 5'h08;
  localparam logic [4:0] KEY_UP    = 5'h10;

  // Configuration register indexes.
  localparam logic CFG_HOLD_TICKS   = 1'b0;
  localparam logic CFG_REPEAT_DELAY = 1'b1;

  localparam logic [7:0]         HOLD_TICKS_RST   = 8'd60;
  localparam logic [7:0]         REPEAT_DELAY_RST = 8'd20;
  localparam logic signed [10:0] ALARM_LOW_RST    = 11'sd500;
  localparam logic signed [10:0] ALARM_HIGH_RST   = 11'sd800;
  localparam logic [5:0]         LEDS_OFF         = 6'h3F;
  localparam logic [7:0]         SIGN_MINUS       = 8'h80;

  typedef enum logic [2:0] {
    MODE_CUR    = 3'd0,
    MODE_MIN    = 3'd1,
    MODE_MAX    = 3'd2,
    MODE_SET_LO = 3'd3,
    MODE_SET_HI = 3'd4
  } mode_e;

  typedef struct packed {
    logic       func;
    logic [4:0] keys;
    logic       meas_ok;
    logic       meas_sign;
    logic [6:0] meas_whole;
    logic [3:0] meas_tenths;
  } tmc_item_t;

  typedef struct packed {
    mode_e      view_mode;
    logic [5:0] led_bits;
    logic [7:0] digit_sign;
    logic [7:0] digit_hundreds;
    logic [7:0] digit_tens;
    logic [7:0] digit_ones;
  } tmc_res_t;

endpackage

[sv/tmc_disp.sv]
// ----------------------------------------------------------------------------
// Thermometer display encoder
// Turns a signed value in tenths into four seven-segment codes.
// ----------------------------------------------------------------------------
module tmc_disp import tmc_pkg::*; (
  input  logic signed [11:0] val_i,
  output logic [3:0][7:0]    dig_o
);

  function automatic logic [7:0] seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'b00111111;
      4'd1:    s = 8'b00000110;
      4'd2:    s = 8'b01011011;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'b01101111;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  logic        neg;
  logic [11:0] mag;
  logic [9:0]  m;
  logic [15:0] prod_h;
  logic [3:0]  hund;
  logic [9:0]  hund_x100;
  logic [6:0]  rem;
  logic [14:0] prod_t;
  logic [3:0]  tens;
  logic [3:0]  ones;

  always_comb begin
    neg  = val_i[11];
    mag  = neg ? 12'(-val_i) : 12'(val_i);
    m    = (mag > 12'd999) ? 10'd999 : mag[9:0];
    // Division by 100 and by 10 through reciprocal multiplication; exact
    // over the whole saturated range.
    prod_h    = 16'(m) * 16'd41;
    hund      = prod_h[15:12];
    hund_x100 = 10'(hund) * 10'd100;
    rem       = 7'(m - hund_x100);
    prod_t    = 15'(rem) * 15'd205;
    tens      = prod_t[14:11];
    ones      = 4'(rem - 7'(tens) * 7'd10);

    dig_o[3] = neg ? SIGN_MINUS : 8'h00;
    dig_o[2] = (m < 10'd100) ? 8'h00 : seg(hund);
    dig_o[1] = 8'h80 | seg(tens);
    dig_o[0] = seg(ones);
  end

endmodule

[sv/tmc_core.sv]
// ----------------------------------------------------------------------------
// Thermometer menu core
// Holds the controller state and computes the next state and result word.
// ----------------------------------------------------------------------------
module tmc_core import tmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  tmc_item_t item_i,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output tmc_res_t  res_o
);

  function automatic logic signed [10:0] sat_thr(input logic signed [10:0] v,
                                                 input logic signed [1:0]  d);
    logic signed [11:0] s;
    s = 12'(v) + 12'(d);
    if (s > 12'sd999)  s = 12'sd999;
    if (s < -12'sd999) s = -12'sd999;
    return s[10:0];
  endfunction

  logic [7:0]         hold_ticks_q, repeat_delay_q;
  mode_e              mode_q, mode_d, mode_a;
  logic [7:0]         hold_q, hold_d, hold_a;
  logic [4:0]         prev_keys_q, prev_keys_d;
  logic               latch_q, latch_d;
  logic [7:0]         rpt_q, rpt_d;
  logic signed [11:0] now_q, now_d, low_q, low_d, high_q, high_d;
  logic signed [10:0] alo_q, alo_d, ahi_q, ahi_d;
  logic               seen_q, seen_d;
  logic [3:0][7:0]    dig_q, dig_d;
  logic [5:0]         led_q, led_d;

  logic [4:0]         act;
  logic               all_rel, hit;
  logic signed [1:0]  step;
  logic signed [11:0] show_val, meas_val;
  logic [11:0]        meas_mag;
  logic [3:0][7:0]    show_dig;

  tmc_disp u_disp (
    .val_i (show_val),
    .dig_o (show_dig)
  );

  always_comb begin
    mode_d      = mode_q;
    hold_d      = hold_q;
    prev_keys_d = prev_keys_q;
    latch_d     = latch_q;
    rpt_d       = rpt_q;
    now_d       = now_q;
    low_d       = low_q;
    high_d      = high_q;
    alo_d       = alo_q;
    ahi_d       = ahi_q;
    seen_d      = seen_q;
    dig_d       = dig_q;
    led_d       = led_q;
    mode_a      = mode_q;
    hold_a      = hold_q;
    step        = 2'sd0;
    show_val    = now_q;

    act      = ~item_i.keys;
    all_rel  = (item_i.keys == KEYS_ALL);
    hit      = !all_rel && (item_i.keys == prev_keys_q);
    meas_mag = 12'(item_i.meas_whole) * 12'd10 + 12'(item_i.meas_tenths);
    meas_val = item_i.meas_sign ? -$signed(meas_mag) : $signed(meas_mag);

    if (!item_i.func) begin
      // A held pattern acts once on its first repeated sample.
      if (hit && !latch_q) begin
        case (act)
          KEY_VIEW: begin
            if (mode_q == MODE_CUR) begin
              mode_a = MODE_MIN;
              hold_a = hold_ticks_q;
            end else begin
              mode_a = MODE_CUR;
              hold_a = 8'd0;
            end
          end
          KEY_RESET: begin
            low_d  = now_q;
            high_d = now_q;
          end
          KEY_SET: mode_a = (mode_q == MODE_SET_LO) ? MODE_SET_HI : MODE_SET_LO;
          default: ;
        endcase
      end
      if (hit) latch_d = 1'b1;

      // Nudge keys never change the mode, so the old mode selects the target.
      if (hit && (rpt_q == 8'd0 || rpt_q > repeat_delay_q)) begin
        if (act == KEY_DOWN)    step = -2'sd1;
        else if (act == KEY_UP) step = 2'sd1;
        if (step != 2'sd0) begin
          if (mode_q == MODE_SET_LO) alo_d = sat_thr(alo_q, step);
          if (mode_q == MODE_SET_HI) ahi_d = sat_thr(ahi_q, step);
        end
      end
      if (hit && rpt_q <= repeat_delay_q && rpt_q != 8'hFF) rpt_d = rpt_q + 8'd1;
      if (all_rel) begin
        latch_d = 1'b0;
        rpt_d   = 8'd0;
      end
      prev_keys_d = item_i.keys;

      mode_d = mode_a;
      hold_d = hold_a;
      if (hold_a != 8'd0) begin
        hold_d = hold_a - 8'd1;
      end else if (mode_a == MODE_MIN) begin
        mode_d = MODE_MAX;
        hold_d = hold_ticks_q;
      end else if (mode_a == MODE_MAX) begin
        mode_d = MODE_CUR;
      end

      case (mode_d)
        MODE_MIN:    show_val = low_d;
        MODE_MAX:    show_val = high_d;
        MODE_SET_LO: show_val = 12'(alo_d);
        MODE_SET_HI: show_val = 12'(ahi_d);
        default:     show_val = now_q;
      endcase
      if (mode_d <= MODE_SET_HI) begin
        dig_d      = show_dig;
        led_d[4:0] = ~(5'd1 << mode_d);
      end
      led_d[5] = !((now_q < 12'(alo_d)) || (now_q > 12'(ahi_d)));
    end else if (item_i.meas_ok) begin
      now_d = meas_val;
      if (!seen_q) begin
        low_d  = meas_val;
        high_d = meas_val;
        seen_d = 1'b1;
      end else begin
        if (meas_val < low_q)  low_d  = meas_val;
        if (meas_val > high_q) high_d = meas_val;
      end
    end

    res_o.view_mode      = mode_d;
    res_o.led_bits       = led_d;
    res_o.digit_sign     = dig_d[3];
    res_o.digit_hundreds = dig_d[2];
    res_o.digit_tens     = dig_d[1];
    res_o.digit_ones     = dig_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q   <= HOLD_TICKS_RST;
      repeat_delay_q <= REPEAT_DELAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HOLD_TICKS:   hold_ticks_q   <= cfg_data_i;
        CFG_REPEAT_DELAY: repeat_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CUR;
      hold_q      <= 8'd0;
      prev_keys_q <= 5'd0;
      latch_q     <= 1'b0;
      rpt_q       <= 8'd0;
      now_q       <= 12'sd0;
      low_q       <= 12'sd0;
      high_q      <= 12'sd0;
      alo_q       <= ALARM_LOW_RST;
      ahi_q       <= ALARM_HIGH_RST;
      seen_q      <= 1'b0;
      dig_q       <= '0;
      led_q       <= LEDS_OFF;
    end else if (step_i) begin
      mode_q      <= mode_d;
      hold_q      <= hold_d;
      prev_keys_q <= prev_keys_d;
      latch_q     <= latch_d;
      rpt_q       <= rpt_d;
      now_q       <= now_d;
      low_q       <= low_d;
      high_q      <= high_d;
      alo_q       <= alo_d;
      ahi_q       <= ahi_d;
      seen_q      <= seen_d;
      dig_q       <= dig_d;
      led_q       <= led_d;
    end
  end

endmodule

[sv/thermometer_menu_controller.sv]
// Throughput: one word per cycle unless the output stalls; each accepted word is
// held in the input register, then in the result register, and the state update
// and display encoding are one combinational step between the two registers.
// Reset: asynchronous and active low; clears the pipeline valids and puts every
// state register, threshold and configuration register at its default.
// ----------------------------------------------------------------------------
// Thermometer menu controller top level
// Stream wrapper with an input register and an output register around the core.
// ----------------------------------------------------------------------------
module thermometer_menu_controller import tmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // keys[4:0], meas_ok[5], meas_sign[6], meas_whole[13:7], meas_tenths[17:14]
  input  logic [23:0] s_axis_tdata,
  // func[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // digit_ones[7:0], digit_tens[15:8], digit_hundreds[23:16],
  // digit_sign[31:24], led_bits[37:32], view_mode[40:38]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  logic      in_vld_q;
  tmc_item_t in_q;
  logic      out_vld_q;
  tmc_res_t  out_q;
  tmc_res_t  res;
  logic      adv, fire;

  assign adv           = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;

  tmc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (fire),
    .item_i     (in_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (fire)          out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.func        <= s_axis_tuser;
      in_q.keys        <= s_axis_tdata[4:0];
      in_q.meas_ok     <= s_axis_tdata[5];
      in_q.meas_sign   <= s_axis_tdata[6];
      in_q.meas_whole  <= s_axis_tdata[13:7];
      in_q.meas_tenths <= s_axis_tdata[17:14];
    end
    if (fire) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.view_mode, out_q.led_bits, out_q.digit_sign,
                          out_q.digit_hundreds, out_q.digit_tens, out_q.digit_ones};

`ifndef SYNTH
  // An empty output register never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready) else $error("input stalled with empty output");

  // A processed word always lands in the output register.
  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q) else $error("processed word lost");

  // At most one mode LED is lit.
  a_mode_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $countones(~out_q.led_bits[4:0]) <= 1)
    else $error("more than one mode LED lit");

  // The sign digit only ever shows the minus segment.
  a_sign_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.digit_sign == 8'h00 || out_q.digit_sign == SIGN_MINUS))
    else $error("bad sign digit");
`endif

endmodule

[tb/sv/tmc_checker.sv]
// ----------------------------------------------------------------------------
// Thermometer menu controller checker
// Watches the input, result and configuration ports, keeps its own copy of
// the menu state, predicts the display word for every accepted input word and
// compares each result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tmc_checker import tmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // keys[4:0], meas_ok[5], meas_sign[6], meas_whole[13:7], meas_tenths[17:14]
  input  logic [23:0] s_tdata_i,
  // func[0]
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // digit_ones[7:0], digit_tens[15:8], digit_hundreds[23:16],
  // digit_sign[31:24], led_bits[37:32], view_mode[40:38]
  input  logic [47:0] m_tdata_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output int          pending_o,
  output int          err_count_o
);

  localparam int THRESH_MAX  = 999;
  localparam int SHOWN_MAX   = 999;
  localparam int PRINT_LIMIT = 100;

  localparam logic [7:0] SEG_CODE [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // Configuration copy.
  logic [7:0] hold_cfg;
  logic [7:0] delay_cfg;

  // Menu state copy; temperatures and thresholds in signed tenths of a degree.
  mode_e      view_q;
  logic [7:0] hold_cnt;
  logic [4:0] last_keys;
  logic       latched;
  logic [7:0] rep_cnt;
  int         t_now;
  int         t_min;
  int         t_max;
  int         thr_lo;
  int         thr_hi;
  logic       have_reading;
  logic [7:0] seg_q [4];
  logic [5:0] led_q;

  tmc_res_t   display_q [$];

  function automatic int limit_threshold(input int v);
    if (v > THRESH_MAX) return THRESH_MAX;
    if (v < -THRESH_MAX) return -THRESH_MAX;
    return v;
  endfunction

  task automatic load_digits(input int v);
    int mag;
    mag = (v < 0) ? -v : v;
    seg_q[3] = (v < 0) ? SIGN_MINUS : 8'h00;
    if (mag > SHOWN_MAX) mag = SHOWN_MAX;
    seg_q[2] = (mag < 100) ? 8'h00 : SEG_CODE[mag / 100];
    seg_q[1] = 8'h80 | SEG_CODE[(mag / 10) % 10];
    seg_q[0] = SEG_CODE[mag % 10];
  endtask

  task automatic apply_poll(input logic [4:0] k);
    logic [4:0] act;
    int         step;
    int         shown;
    act = KEYS_ALL ^ k;
    // A key pattern acts only when it repeats the previous sample.
    if (k != KEYS_ALL && k == last_keys) begin
      if (!latched) begin
        if (act == KEY_VIEW) begin
          if (view_q == MODE_CUR) begin
            view_q   = MODE_MIN;
            hold_cnt = hold_cfg;
          end else begin
            view_q   = MODE_CUR;
            hold_cnt = '0;
          end
        end else if (act == KEY_RESET) begin
          t_min = t_now;
          t_max = t_now;
        end else if (act == KEY_SET) begin
          view_q = (view_q == MODE_SET_LO) ? MODE_SET_HI : MODE_SET_LO;
        end
        latched = 1'b1;
      end
      if (rep_cnt == 0 || rep_cnt > delay_cfg) begin
        step = 0;
        if (act == KEY_DOWN) step = -1;
        else if (act == KEY_UP) step = 1;
        if (step != 0) begin
          if (view_q == MODE_SET_LO) thr_lo = limit_threshold(thr_lo + step);
          if (view_q == MODE_SET_HI) thr_hi = limit_threshold(thr_hi + step);
        end
      end
      if (rep_cnt <= delay_cfg && rep_cnt != 8'hFF) rep_cnt++;
    end
    if (k == KEYS_ALL) begin
      latched = 1'b0;
      rep_cnt = '0;
    end
    last_keys = k;

    if (hold_cnt != 0) begin
      hold_cnt--;
    end else if (view_q == MODE_MIN) begin
      view_q   = MODE_MAX;
      hold_cnt = hold_cfg;
    end else if (view_q == MODE_MAX) begin
      view_q = MODE_CUR;
    end

    case (view_q)
      MODE_MIN:    shown = t_min;
      MODE_MAX:    shown = t_max;
      MODE_SET_LO: shown = thr_lo;
      MODE_SET_HI: shown = thr_hi;
      default:     shown = t_now;
    endcase
    led_q[4:0] = 5'h1F ^ (5'd1 << view_q);
    load_digits(shown);
    led_q[5] = (t_now < thr_lo || t_now > thr_hi) ? 1'b0 : 1'b1;
  endtask

  task automatic apply_reading(input tmc_item_t w);
    int v;
    if (!w.meas_ok) return;
    v = int'(w.meas_whole) * 10 + int'(w.meas_tenths);
    if (w.meas_sign) v = -v;
    t_now = v;
    if (!have_reading) begin
      t_min        = v;
      t_max        = v;
      have_reading = 1'b1;
    end else begin
      if (v < t_min) t_min = v;
      if (v > t_max) t_max = v;
    end
  endtask

  function automatic tmc_res_t current_display();
    tmc_res_t r;
    r.digit_ones     = seg_q[0];
    r.digit_tens     = seg_q[1];
    r.digit_hundreds = seg_q[2];
    r.digit_sign     = seg_q[3];
    r.led_bits       = led_q;
    r.view_mode      = view_q;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count_o < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    err_count_o++;
  endtask

  task automatic cmp_field(input string name, input logic [7:0] got,
                           input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tmc_item_t w;
    tmc_res_t  got;
    tmc_res_t  want;
    if (!rst_ni) begin
      hold_cfg     = HOLD_TICKS_RST;
      delay_cfg    = REPEAT_DELAY_RST;
      view_q       = MODE_CUR;
      hold_cnt     = '0;
      last_keys    = '0;
      latched      = 1'b0;
      rep_cnt      = '0;
      t_now        = 0;
      t_min        = 0;
      t_max        = 0;
      thr_lo       = ALARM_LOW_RST;
      thr_hi       = ALARM_HIGH_RST;
      have_reading = 1'b0;
      for (int i = 0; i < 4; i++) seg_q[i] = '0;
      led_q        = LEDS_OFF;
      display_q.delete();
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HOLD_TICKS) hold_cfg = cfg_data_i;
        else delay_cfg = cfg_data_i;
      end
      // Compare before predicting so a stray word can never match the word
      // accepted at the same edge.
      if (m_tvalid_i && m_tready_i) begin
        if (display_q.size() == 0) begin
          report_mismatch("result word with no prediction pending");
        end else begin
          want = display_q.pop_front();
          got  = tmc_res_t'(m_tdata_i[40:0]);
          cmp_field("digit_ones", got.digit_ones, want.digit_ones);
          cmp_field("digit_tens", got.digit_tens, want.digit_tens);
          cmp_field("digit_hundreds", got.digit_hundreds, want.digit_hundreds);
          cmp_field("digit_sign", got.digit_sign, want.digit_sign);
          cmp_field("led_bits", got.led_bits, want.led_bits);
          cmp_field("view_mode", got.view_mode, want.view_mode);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        w.func        = s_tuser_i;
        w.keys        = s_tdata_i[4:0];
        w.meas_ok     = s_tdata_i[5];
        w.meas_sign   = s_tdata_i[6];
        w.meas_whole  = s_tdata_i[13:7];
        w.meas_tenths = s_tdata_i[17:14];
        if (w.func) apply_reading(w);
        else apply_poll(w.keys);
        display_q.push_back(current_display());
      end
      pending_o <= display_q.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Thermometer menu controller testbench
// Drives key polls and measurements through the input stream with random
// gaps and result stalls, walks the configuration through several settings
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import tmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PRESSURE_AT    = 600;
  localparam int PRESSURE_LEN   = 200;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_we;
  logic        cfg_idx;
  logic [7:0]  cfg_data;

  int pending;
  int err_count;
  int words_sent;
  int send_burst;
  int quiet;

  thermometer_menu_controller uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  tmc_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .err_count_o (err_count)
  );

  always #10 clk = ~clk;

  task automatic send_word(input tmc_item_t w);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      if ($urandom_range(0, 24) == 0) send_burst = $urandom_range(10, 40);
      gap = $urandom_range(0, 7);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, w.meas_tenths, w.meas_whole, w.meas_sign, w.meas_ok, w.keys};
    s_axis_tuser  <= w.func;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  function automatic tmc_item_t random_meas();
    tmc_item_t w;
    w.func        = 1'b1;
    w.keys        = 5'($urandom_range(0, 31));
    w.meas_ok     = ($urandom_range(0, 7) != 0);
    w.meas_sign   = 1'($urandom_range(0, 1));
    w.meas_whole  = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 40))
                                                : 7'($urandom_range(0, 127));
    w.meas_tenths = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 9))
                                                : 4'($urandom_range(0, 15));
    return w;
  endfunction

  // Key poll word; the measurement fields ride along with random content.
  task automatic tick(input logic [4:0] k);
    tmc_item_t w;
    w      = random_meas();
    w.func = 1'b0;
    w.keys = k;
    send_word(w);
  endtask

  task automatic measure(input logic ok, input logic sign, input logic [6:0] whole,
                         input logic [3:0] tenths);
    tmc_item_t w;
    w             = random_meas();
    w.meas_ok     = ok;
    w.meas_sign   = sign;
    w.meas_whole  = whole;
    w.meas_tenths = tenths;
    send_word(w);
  endtask

  // Holds one key pattern for n polls; the second poll is the first press.
  task automatic hold_key(input logic [4:0] act, input int n);
    repeat (n) tick(KEYS_ALL ^ act);
    tick(KEYS_ALL);
  endtask

  task automatic press_run();
    logic [4:0] act;
    int         len;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 15) act = KEY_VIEW;
    else if (r < 30) act = KEY_RESET;
    else if (r < 42) act = KEY_SET;
    else if (r < 62) act = KEY_DOWN;
    else if (r < 82) act = KEY_UP;
    else act = 5'($urandom_range(1, 31));
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6);
    repeat (len) begin
      if ($urandom_range(0, 9) == 0) send_word(random_meas());
      tick(KEYS_ALL ^ act);
    end
    repeat ($urandom_range(1, 3)) tick(KEYS_ALL);
  endtask

  task automatic random_traffic(input int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) begin
      case ($urandom_range(0, 7))
        0:       tick(5'($urandom_range(0, 31)));
        1:       send_word(random_meas());
        default: press_run();
      endcase
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] hold, input logic [7:0] delay);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_HOLD_TICKS;
    cfg_data <= hold;
    @(posedge clk);
    cfg_idx  <= CFG_REPEAT_DELAY;
    cfg_data <= delay;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Result side: random stalls, runs without stalls, and one long hold-off
  // that lets the block fill up while words keep coming.
  initial begin : result_sink
    int stall;
    int burst;
    int taken;
    burst = 0;
    taken = 0;
    wait (rst_n);
    forever begin
      if (taken == PRESSURE_AT) begin
        stall = PRESSURE_LEN;
      end else if (burst > 0) begin
        stall = 0;
        burst--;
      end else begin
        if ($urandom_range(0, 24) == 0) burst = $urandom_range(10, 40);
        stall = $urandom_range(0, 7);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("FAIL thermometer_menu_controller");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_HOLD_TICKS;
    cfg_data      = '0;
    words_sent    = 0;
    send_burst    = 0;
    quiet         = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings. The previous sample resets to all
    // pressed, so an all-pressed poll acts at once as a multi-key press.
    tick(5'h00);
    tick(5'h00);
    tick(KEYS_ALL);
    measure(1'b0, 1'b1, 7'd127, 4'd15);
    measure(1'b1, 1'b0, 7'd0, 4'd0);
    measure(1'b1, 1'b1, 7'd127, 4'd15);
    measure(1'b1, 1'b0, 7'd127, 4'd15);
    measure(1'b1, 1'b0, 7'd23, 4'd4);
    hold_key(KEY_UP, 2);
    hold_key(KEY_RESET, 2);
    hold_key(KEY_VIEW, 2);
    hold_key(KEY_SET, 2);
    hold_key(KEY_DOWN, 2);
    hold_key(KEY_SET, 2);
    hold_key(KEY_UP, 2);
    random_traffic(125);

    // Shortest hold and repeat: every held poll nudges, and the high
    // threshold is driven into its upper limit.
    settle();
    write_cfg(8'd0, 8'd0);
    tick(KEYS_ALL);
    hold_key(KEY_VIEW, 2);
    tick(KEYS_ALL);
    tick(KEYS_ALL);
    hold_key(KEY_SET, 2);
    hold_key(KEY_DOWN, 40);
    hold_key(KEY_SET, 2);
    hold_key(KEY_UP, 210);
    random_traffic(125);

    // Longest hold and repeat: the repeat counter has to stop at its top.
    settle();
    write_cfg(8'd255, 8'd255);
    tick(KEYS_ALL);
    hold_key(KEY_UP, 300);
    random_traffic(125);

    settle();
    write_cfg(8'($urandom_range(1, 12)), 8'($urandom_range(0, 6)));
    random_traffic(125);

    settle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("PASS thermometer_menu_controller");
    end else begin
      $display("FAIL thermometer_menu_controller");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/tmc_pkg.sv
sv/tmc_disp.sv
sv/tmc_core.sv
sv/thermometer_menu_controller.sv
tb/sv/tmc_checker.sv
tb/sv/tb_top.sv
